@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When a holds, c holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// When a holds, c holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ rtl/tgd_pkg.sv @@
package tgd_pkg;

    localparam int MAX_POSITION_BINS_DEF = 1024;
    localparam int MAX_GAUSS_BINS_DEF    = 16;
    localparam int MAX_LORENTZ_BINS_DEF  = 16;

    localparam int CELL_W   = 48;
    localparam int ADD_W    = 33;
    localparam int FRAC_W   = 16;
    localparam int COORD_W  = 32;
    localparam int INT_W    = 24;
    localparam int CADDR_W  = 18;
    localparam int BINS_W   = 5;
    localparam int PADDR_W  = 5;

    localparam logic [1:0] STAT_DEPOSITED = 2'd0;
    localparam logic [1:0] STAT_DROPPED   = 2'd1;
    localparam logic [1:0] STAT_READ      = 2'd2;

    localparam logic [2:0] REG_POSITION_MIN = 3'd0;
    localparam logic [2:0] REG_GAUSS_MIN    = 3'd1;
    localparam logic [2:0] REG_LORENTZ_MIN  = 3'd2;
    localparam logic [2:0] REG_POSITION_INV = 3'd3;
    localparam logic [2:0] REG_GAUSS_INV    = 3'd4;
    localparam logic [2:0] REG_LORENTZ_INV  = 3'd5;
    localparam logic [2:0] REG_GAUSS_BINS   = 3'd6;
    localparam logic [2:0] REG_LORENTZ_BINS = 3'd7;

    localparam logic ACT_DEPOSIT = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_ROW,
        ST_BASE,
        ST_DEP,
        ST_RDREQ,
        ST_RDWAIT,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic valid;
        logic busy;
    } t_pipe_stat;

endpackage

@@ rtl/trilinear_grid_deposit_unit.sv @@
// Trilinear grid deposit unit.
// The input channel (i_in_valid / o_in_stall) takes one beat per item: a
// deposit spreads an intensity over the eight cells around three mapped
// coordinates, a read returns one cell of the grid by flat address.
// Every item gives exactly one beat on the output channel (o_out_valid /
// i_out_stall): a status and, for reads, the cell value.
// Items are handled one at a time. A read requests its cell from the grid
// memory, waits for the read data and loads the result. A deposit maps its
// axes on a shared 32x32 multiplier, sets up the row and base address,
// issues eight read-modify-write accesses on the single grid memory, drains
// the pipeline and loads the result; a dropped one skips the accesses.
// After reset the grid memory is cleared one cell per cycle, through every
// cell of the grid (262144 by default); items wait.
// The configuration port stays open at all times.
// The result sits in an output register; while the receiver stalls, the
// block holds it and waits before finishing the next item.
module trilinear_grid_deposit_unit #(
    parameter int MAX_POSITION_BINS = tgd_pkg::MAX_POSITION_BINS_DEF,
    parameter int MAX_GAUSS_BINS    = tgd_pkg::MAX_GAUSS_BINS_DEF,
    parameter int MAX_LORENTZ_BINS  = tgd_pkg::MAX_LORENTZ_BINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [tgd_pkg::INT_W-1:0]     i_intensity,
    input  logic signed [tgd_pkg::COORD_W-1:0] i_position,
    input  logic signed [tgd_pkg::COORD_W-1:0] i_gauss_width,
    input  logic signed [tgd_pkg::COORD_W-1:0] i_lorentz_width,
    input  logic [tgd_pkg::CADDR_W-1:0]   i_cell_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [tgd_pkg::CELL_W-1:0]    o_cell_value,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tgd_pkg::*;

    `include "assert_macros.svh"

    localparam longint GridDepth = longint'(MAX_POSITION_BINS) * MAX_GAUSS_BINS
                                   * MAX_LORENTZ_BINS;
    localparam int AW  = $clog2(GridDepth);
    localparam int KW  = $clog2(MAX_POSITION_BINS);
    localparam int LW  = $clog2(MAX_GAUSS_BINS);
    localparam int MW  = $clog2(MAX_LORENTZ_BINS);
    localparam int GW  = $clog2(MAX_GAUSS_BINS + 1);
    localparam int NW  = $clog2(MAX_LORENTZ_BINS + 1);
    localparam int RW  = $clog2(MAX_POSITION_BINS * MAX_GAUSS_BINS);
    localparam int RSW = KW + GW + 1;
    localparam int BSW = RW + NW + 1;

    t_state r_state, n_state;

    logic [COORD_W-1:0] r_pos_min, r_gauss_min, r_lor_min;
    logic [COORD_W-1:0] r_pos_inv, r_gauss_inv, r_lor_inv;
    logic [BINS_W-1:0]  r_gauss_bins, r_lor_bins;

    logic               r_action;
    logic [INT_W-1:0]   r_intensity;
    logic [COORD_W-1:0] r_pos, r_gw, r_lw;
    logic [CADDR_W-1:0] r_cell;

    logic [1:0]         r_ax;
    logic               r_drop;
    logic [KW-1:0]      r_k;
    logic [LW-1:0]      r_l;
    logic [MW-1:0]      r_m;
    logic [FRAC_W-1:0]  r_fp, r_fg, r_fl;
    logic [RW-1:0]      r_row;
    logic [AW-1:0]      r_base;
    logic [3:0]         r_cnt;
    logic [AW-1:0]      r_clr;

    logic               r_wv;
    logic [AW-1:0]      r_waddr;
    logic [ADD_W-1:0]   r_wadd;

    logic [1:0]         r_res_status;
    logic [CELL_W-1:0]  r_res_value;
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [CELL_W-1:0]  r_out_value;

    logic               accept, cfg_we, out_load, issue, in_range, clr_done;
    logic [GW-1:0]      ng;
    logic [NW-1:0]      nl;
    logic [AW-1:0]      stride, nl_ext;
    logic [COORD_W-1:0] ax_coord, ax_min, ax_inv;
    logic [COORD_W-1:0] ax_bin;
    logic [FRAC_W-1:0]  ax_frac;
    logic               ax_neg;
    logic [COORD_W:0]   ax_limit;
    logic [RSW-1:0]     row_sum;
    logic [BSW-1:0]     base_sum;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [CELL_W-1:0]  mem_wdata, mem_rdata;
    logic [CELL_W:0]    sat_sum;
    t_pipe_stat         pipe_stat;
    logic [AW-1:0]      pipe_addr;
    logic [ADD_W-1:0]   pipe_add;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_min    <= '0;
            r_gauss_min  <= '0;
            r_lor_min    <= '0;
            r_pos_inv    <= COORD_W'(65536);
            r_gauss_inv  <= COORD_W'(65536);
            r_lor_inv    <= COORD_W'(65536);
            r_gauss_bins <= BINS_W'(16);
            r_lor_bins   <= BINS_W'(16);
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_POSITION_MIN: r_pos_min    <= pwdata;
                REG_GAUSS_MIN:    r_gauss_min  <= pwdata;
                REG_LORENTZ_MIN:  r_lor_min    <= pwdata;
                REG_POSITION_INV: r_pos_inv    <= pwdata;
                REG_GAUSS_INV:    r_gauss_inv  <= pwdata;
                REG_LORENTZ_INV:  r_lor_inv    <= pwdata;
                REG_GAUSS_BINS:   r_gauss_bins <= pwdata[BINS_W-1:0];
                REG_LORENTZ_BINS: r_lor_bins   <= pwdata[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_POSITION_MIN: prdata = r_pos_min;
            REG_GAUSS_MIN:    prdata = r_gauss_min;
            REG_LORENTZ_MIN:  prdata = r_lor_min;
            REG_POSITION_INV: prdata = r_pos_inv;
            REG_GAUSS_INV:    prdata = r_gauss_inv;
            REG_LORENTZ_INV:  prdata = r_lor_inv;
            REG_GAUSS_BINS:   prdata = 32'(r_gauss_bins);
            REG_LORENTZ_BINS: prdata = 32'(r_lor_bins);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        ng = (int'(r_gauss_bins) < MAX_GAUSS_BINS) ? GW'(r_gauss_bins)
                                                   : GW'(MAX_GAUSS_BINS);
        nl = (int'(r_lor_bins) < MAX_LORENTZ_BINS) ? NW'(r_lor_bins)
                                                   : NW'(MAX_LORENTZ_BINS);
        stride   = AW'((GW+NW)'(ng) * (GW+NW)'(nl));
        nl_ext   = AW'(nl);
        row_sum  = RSW'(r_k) * RSW'(ng) + RSW'(r_l);
        base_sum = BSW'(r_row) * BSW'(nl) + BSW'(r_m);
        in_range = longint'(r_cell) < GridDepth;
        clr_done = r_clr == AW'(GridDepth - 1);
        sat_sum  = {1'b0, mem_rdata} + (CELL_W+1)'(r_wadd);
    end

    always_comb begin
        case (r_ax)
            2'd0: begin
                ax_coord = r_pos;
                ax_min   = r_pos_min;
                ax_inv   = r_pos_inv;
            end
            2'd1: begin
                ax_coord = r_gw;
                ax_min   = r_gauss_min;
                ax_inv   = r_gauss_inv;
            end
            default: begin
                ax_coord = r_lw;
                ax_min   = r_lor_min;
                ax_inv   = r_lor_inv;
            end
        endcase
        case (r_ax)
            2'd1:    ax_limit = (COORD_W+1)'(MAX_POSITION_BINS);
            2'd2:    ax_limit = (COORD_W+1)'(ng);
            default: ax_limit = (COORD_W+1)'(nl);
        endcase
    end

    tgd_axis_map u_axis (
        .i_clk     (i_clk),
        .i_coord   (ax_coord),
        .i_minimum (ax_min),
        .i_inv     (ax_inv),
        .o_bin     (ax_bin),
        .o_frac    (ax_frac),
        .o_neg     (ax_neg)
    );

    tgd_weight_pipe #(
        .AW (AW)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_sel       (r_cnt[2:0]),
        .i_intensity (r_intensity),
        .i_fp        (r_fp),
        .i_fg        (r_fg),
        .i_fl        (r_fl),
        .i_base      (r_base),
        .i_stride    (stride),
        .i_nl        (nl_ext),
        .o_stat      (pipe_stat),
        .o_addr      (pipe_addr),
        .o_add       (pipe_add)
    );

    tgd_ram #(
        .WIDTH (CELL_W),
        .DEPTH (GridDepth)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (clr_done) begin
                n_state = ST_IDLE;
            end
            ST_IDLE:   if (accept) begin
                n_state = (i_action == ACT_READ) ? ST_RDREQ : ST_MAP;
            end
            ST_MAP:    if (r_ax == 2'd3) begin
                n_state = ST_ROW;
            end
            ST_ROW:    n_state = r_drop ? ST_RESP : ST_BASE;
            ST_BASE:   n_state = ST_DEP;
            ST_DEP:    if (r_cnt[3] && !pipe_stat.busy && !r_wv) begin
                n_state = ST_RESP;
            end
            ST_RDREQ:  n_state = ST_RDWAIT;
            ST_RDWAIT: n_state = ST_RESP;
            ST_RESP:   if (out_load) begin
                n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        accept     = i_in_valid && (r_state == ST_IDLE);
        issue      = (r_state == ST_DEP) && !r_cnt[3];
        out_load   = (r_state == ST_RESP) && (!r_out_valid || !i_out_stall);
        mem_we     = (r_state == ST_CLEAR) || r_wv;
        mem_waddr  = (r_state == ST_CLEAR) ? r_clr : r_waddr;
        mem_wdata  = (r_state == ST_CLEAR) ? '0
                   : (sat_sum[CELL_W] ? '1 : sat_sum[CELL_W-1:0]);
        mem_raddr  = (r_state == ST_RDREQ) ? AW'(r_cell) : pipe_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_ax        <= '0;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= pipe_stat.valid;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (accept) begin
                r_ax   <= '0;
                r_cnt  <= '0;
                r_drop <= 1'b0;
            end
            if (r_state == ST_MAP) begin
                r_ax <= r_ax + 2'd1;
                if (r_ax != 2'd0) begin
                    if (ax_neg || ({1'b0, ax_bin} + (COORD_W+1)'(1) >= ax_limit)) begin
                        r_drop <= 1'b1;
                    end
                end
            end
            if (issue) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action    <= i_action;
            r_intensity <= i_intensity;
            r_pos       <= i_position;
            r_gw        <= i_gauss_width;
            r_lw        <= i_lorentz_width;
            r_cell      <= i_cell_address;
        end
        if (r_state == ST_MAP) begin
            case (r_ax)
                2'd1: begin
                    r_k  <= ax_bin[KW-1:0];
                    r_fp <= ax_frac;
                end
                2'd2: begin
                    r_l  <= ax_bin[LW-1:0];
                    r_fg <= ax_frac;
                end
                2'd3: begin
                    r_m  <= ax_bin[MW-1:0];
                    r_fl <= ax_frac;
                end
                default: ;
            endcase
        end
        if (r_state == ST_ROW) begin
            r_row        <= RW'(row_sum);
            r_res_status <= STAT_DROPPED;
            r_res_value  <= '0;
        end
        if (r_state == ST_BASE) begin
            r_base       <= AW'(base_sum);
            r_res_status <= STAT_DEPOSITED;
        end
        if (r_state == ST_RDWAIT) begin
            r_res_status <= STAT_READ;
            r_res_value  <= in_range ? mem_rdata : '0;
        end
        r_waddr <= pipe_addr;
        r_wadd  <= pipe_add;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_cell_value = r_out_value;

    `ASSERT_SAME(a_write_in_deposit, i_clk, i_rst_n, r_wv, r_state == ST_DEP)
    `ASSERT_SAME(a_value_only_on_read, i_clk, i_rst_n,
        o_out_valid && (o_status != STAT_READ), o_cell_value == '0)
    `ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, accept,
        (r_state == ST_MAP) || (r_state == ST_RDREQ))
    `ASSERT_SAME(a_read_kind_matches, i_clk, i_rst_n,
        (r_state == ST_RDWAIT), r_action == ACT_READ)

endmodule

@@ rtl/tgd_ram.sv @@
module tgd_ram #(
    parameter int     WIDTH = 48,
    parameter longint DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/tgd_axis_map.sv @@
module tgd_axis_map (
    input  logic                         i_clk,
    input  logic [tgd_pkg::COORD_W-1:0]  i_coord,
    input  logic [tgd_pkg::COORD_W-1:0]  i_minimum,
    input  logic [tgd_pkg::COORD_W-1:0]  i_inv,
    output logic [tgd_pkg::COORD_W-1:0]  o_bin,
    output logic [tgd_pkg::FRAC_W-1:0]   o_frac,
    output logic                         o_neg
);
    import tgd_pkg::*;

    logic [COORD_W:0]     diff;
    logic [2*COORD_W-1:0] prod;
    logic [2*COORD_W-1:0] r_prod;
    logic                 r_neg;

    always_comb begin
        diff = {i_coord[COORD_W-1], i_coord} - {i_minimum[COORD_W-1], i_minimum};
        prod = diff[COORD_W] ? '0 : diff[COORD_W-1:0] * i_inv;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_neg  <= diff[COORD_W] && (i_inv != '0);
    end

    assign o_bin  = r_prod[2*COORD_W-1:COORD_W];
    assign o_frac = r_prod[COORD_W-1:COORD_W-FRAC_W];
    assign o_neg  = r_neg;

endmodule

@@ rtl/tgd_weight_pipe.sv @@
module tgd_weight_pipe #(
    parameter int AW = 18
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_issue,
    input  logic [2:0]                  i_sel,
    input  logic [tgd_pkg::INT_W-1:0]   i_intensity,
    input  logic [tgd_pkg::FRAC_W-1:0]  i_fp,
    input  logic [tgd_pkg::FRAC_W-1:0]  i_fg,
    input  logic [tgd_pkg::FRAC_W-1:0]  i_fl,
    input  logic [AW-1:0]               i_base,
    input  logic [AW-1:0]               i_stride,
    input  logic [AW-1:0]               i_nl,
    output tgd_pkg::t_pipe_stat         o_stat,
    output logic [AW-1:0]               o_addr,
    output logic [tgd_pkg::ADD_W-1:0]   o_add
);
    import tgd_pkg::*;

    localparam int W_W  = FRAC_W + 1;
    localparam int P1_W = 33;
    localparam int P2_W = 34;

    logic                 r_v1, r_v2, r_v3;
    logic [2:0]           r_sel1;
    logic [1:0]           r_sel2;
    logic [P1_W-1:0]      r_p1;
    logic [P2_W-1:0]      r_p2;
    logic [ADD_W-1:0]     r_add;
    logic [AW-1:0]        r_addr, r_addr2;
    logic [W_W-1:0]       wp, wg, wl;
    logic [INT_W+W_W-1:0] m1;
    logic [P1_W+W_W-1:0]  m2;
    logic [P2_W+W_W-1:0]  m3;

    always_comb begin
        wp = i_sel[2] ? {1'b0, i_fp} : (W_W'(1) << FRAC_W) - {1'b0, i_fp};
        wg = r_sel1[1] ? {1'b0, i_fg} : (W_W'(1) << FRAC_W) - {1'b0, i_fg};
        wl = r_sel2[0] ? {1'b0, i_fl} : (W_W'(1) << FRAC_W) - {1'b0, i_fl};
        m1 = (INT_W+W_W)'(i_intensity) * (INT_W+W_W)'(wp);
        m2 = (P1_W+W_W)'(r_p1) * (P1_W+W_W)'(wg);
        m3 = (P2_W+W_W)'(r_p2) * (P2_W+W_W)'(wl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_sel1  <= i_sel;
        r_p1    <= P1_W'(m1 >> 8);
        r_addr  <= i_base + (i_sel[2] ? i_stride : '0) + (i_sel[1] ? i_nl : '0)
                   + AW'(i_sel[0]);
        r_sel2  <= r_sel1[1:0];
        r_p2    <= P2_W'(m2 >> FRAC_W);
        r_addr2 <= r_addr;
        r_add   <= ADD_W'(m3 >> FRAC_W);
        o_addr  <= r_addr2;
    end

    assign o_add       = r_add;
    assign o_stat.valid = r_v3;
    assign o_stat.busy  = r_v1 | r_v2 | r_v3;

endmodule
